// File: rtl/battery_voltage_to_percent_unit_assert.svh
// assertion macros for the battery voltage to percent unit
// expects clk and rst in scope at the point of use
`ifndef BATTERY_VOLTAGE_TO_PERCENT_UNIT_ASSERT_SVH
`define BATTERY_VOLTAGE_TO_PERCENT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BVP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvp implication check failed");
// implication after the full pipeline latency
`define BVP_ASSERT_LAT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##LATENCY (cons)) \
    else $error("bvp latency check failed");
`else
`define BVP_ASSERT_IMP(lbl, ante, cons)
`define BVP_ASSERT_LAT(lbl, ante, cons)
`endif
`endif

// File: rtl/bvp_pkg.sv
package bvp_pkg;

  // table size, clamped to the stored entries and to at least two points
  localparam int TABLE_POINTS  = 45;
  localparam int STORED_POINTS = 45;
  localparam int USED_POINTS   = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                                 ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam int SEG_N         = USED_POINTS - 1;

  localparam int MV_W      = 13;
  localparam int PCT_W     = 7;
  localparam int PROD_W    = MV_W + PCT_W;
  localparam int DIV_STEPS = PCT_W;
  // input reg, compare, select, product, divider steps, output reg
  localparam int LATENCY   = DIV_STEPS + 5;

  typedef logic [MV_W-1:0]  mv_t;
  typedef logic [PCT_W-1:0] pct_t;

  localparam pct_t PCT_FULL  = 7'd100;
  localparam pct_t PCT_EMPTY = 7'd0;

  localparam mv_t SOC_MV [STORED_POINTS] = '{
    13'd4200, 13'd4180, 13'd4160, 13'd4140, 13'd4120, 13'd4100, 13'd4080, 13'd4060,
    13'd4040, 13'd4020, 13'd4000, 13'd3980, 13'd3960, 13'd3940, 13'd3920, 13'd3900,
    13'd3880, 13'd3860, 13'd3840, 13'd3820, 13'd3800, 13'd3780, 13'd3760, 13'd3740,
    13'd3720, 13'd3700, 13'd3680, 13'd3660, 13'd3640, 13'd3620, 13'd3600, 13'd3580,
    13'd3560, 13'd3540, 13'd3520, 13'd3500, 13'd3480, 13'd3460, 13'd3440, 13'd3420,
    13'd3400, 13'd3380, 13'd3360, 13'd3300, 13'd3000
  };

  localparam pct_t SOC_PCT [STORED_POINTS] = '{
    7'd100, 7'd99, 7'd98, 7'd97, 7'd96, 7'd95, 7'd93, 7'd91,
    7'd89,  7'd87, 7'd85, 7'd83, 7'd80, 7'd77, 7'd74, 7'd71,
    7'd68,  7'd65, 7'd62, 7'd59, 7'd56, 7'd53, 7'd50, 7'd47,
    7'd44,  7'd41, 7'd38, 7'd35, 7'd32, 7'd29, 7'd26, 7'd23,
    7'd20,  7'd17, 7'd15, 7'd13, 7'd11, 7'd9,  7'd7,  7'd5,
    7'd4,   7'd3,  7'd2,  7'd1,  7'd0
  };

  // one stage of the restoring divider
  typedef struct packed {
    logic              valid;
    logic              sat_hi;
    logic              sat_lo;
    logic              zspan;
    logic [PROD_W-1:0] rem;
    mv_t               span;
    pct_t              quo;
    pct_t              base;
  } div_stage_t;

endpackage

// File: rtl/battery_voltage_to_percent_unit.sv
`include "battery_voltage_to_percent_unit_assert.svh"
// battery voltage to charge percentage, piecewise linear over a constant table
//
// request channel: vbat_mv (mV, unsigned) is taken at a rising edge where start
//   is high and busy is low; busy is only high while rst is held, so a new
//   request can be taken in every cycle
// result channel: charge_percent (0 to 100) is shown for exactly one cycle with
//   done high; the receiver has no way to hold it off and needs none
// done rises once the request has passed the input, compare, select, product,
//   divider and output registers; results come out in request order
// throughput: one request per cycle, set by the pipeline of table compare,
//   segment select, one 13x7 multiply and a divider that resolves one quotient
//   bit per stage (seven stages)
// at or above the top table point the answer is 100, at or below the bottom
//   point it is 0, otherwise lower percent plus the floored interpolation
// reset: synchronous rst clears every valid bit, so requests in flight are
//   dropped and no done pulse follows; there is no other kept state
module battery_voltage_to_percent_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [bvp_pkg::MV_W-1:0]  vbat_mv,
  output logic                      done,
  output logic [bvp_pkg::PCT_W-1:0] charge_percent
);
  import bvp_pkg::*;

  // stage 1: input register
  logic v1;
  mv_t  vin1;

  // stage 2: compare against every table point
  logic                   v2;
  mv_t                    vin2;
  logic                   hi2;
  logic                   lo2;
  logic [USED_POINTS-1:0] gt2;
  logic [USED_POINTS-1:0] gt_next;
  logic                   hi_next;
  logic                   lo_next;

  // stage 3: selected segment
  logic             v3;
  logic             hi3;
  logic             lo3;
  mv_t              diff3;
  pct_t             rise3;
  mv_t              span3;
  pct_t             base3;
  logic [SEG_N-1:0] seg_hot;
  mv_t              sel_vl;
  mv_t              sel_span;
  pct_t             sel_rise;
  pct_t             sel_base;

  // stage 4 on: product then divider
  div_stage_t div_q [DIV_STEPS+1];
  div_stage_t div_first;

  logic [PCT_W:0] sum_pct;
  pct_t           pct_next;

  // no requests while in reset
  assign busy = rst;

  always_ff @(posedge clk) begin
    vin1 <= vbat_mv;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
  end

  // the table falls strictly, so gt is a thermometer code
  always_comb begin
    for (int j = 0; j < USED_POINTS; j++) begin
      gt_next[j] = SOC_MV[j] > vin1;
    end
    hi_next = vin1 >= SOC_MV[0];
    lo_next = vin1 <= SOC_MV[USED_POINTS-1];
  end

  always_ff @(posedge clk) begin
    vin2 <= vin1;
    gt2  <= gt_next;
    hi2  <= hi_next;
    lo2  <= lo_next;
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // last point above the voltage opens the bracketing segment;
  // a voltage on a point lands in the segment above it
  always_comb begin
    sel_vl   = '0;
    sel_span = '0;
    sel_rise = '0;
    sel_base = '0;
    for (int i = 0; i < SEG_N; i++) begin
      seg_hot[i] = gt2[i] & ~gt2[i+1];
      if (seg_hot[i]) begin
        sel_vl   = sel_vl   | SOC_MV[i+1];
        sel_span = sel_span | (SOC_MV[i] - SOC_MV[i+1]);
        sel_base = sel_base | SOC_PCT[i+1];
        if (SOC_PCT[i] >= SOC_PCT[i+1]) begin
          sel_rise = sel_rise | (SOC_PCT[i] - SOC_PCT[i+1]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    hi3   <= hi2;
    lo3   <= lo2;
    diff3 <= vin2 - sel_vl;
    rise3 <= sel_rise;
    span3 <= sel_span;
    base3 <= sel_base;
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  // product is below span * 128, so seven quotient bits suffice;
  // valid is masked by rst on its way into the register
  always_comb begin
    div_first.valid  = v3 & ~rst;
    div_first.sat_hi = hi3;
    div_first.sat_lo = lo3;
    div_first.zspan  = (span3 == '0);
    div_first.rem    = PROD_W'(diff3) * PROD_W'(rise3);
    div_first.span   = span3;
    div_first.quo    = '0;
    div_first.base   = base3;
  end

  always_ff @(posedge clk) begin
    div_q[0] <= div_first;
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int QB = DIV_STEPS - 1 - s;
    logic [PROD_W:0] trial;
    logic [PROD_W:0] rem_ext;
    div_stage_t      step_next;

    always_comb begin
      trial           = (PROD_W + 1)'(div_q[s].span) << QB;
      rem_ext         = {1'b0, div_q[s].rem};
      step_next       = div_q[s];
      step_next.valid = div_q[s].valid & ~rst;
      if (rem_ext >= trial) begin
        step_next.rem     = div_q[s].rem - trial[PROD_W-1:0];
        step_next.quo[QB] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      div_q[s+1] <= step_next;
    end
  end

  // saturation and the zero-span case take priority over the quotient
  always_comb begin
    sum_pct = {1'b0, div_q[DIV_STEPS].base} + {1'b0, div_q[DIV_STEPS].quo};
    priority if (div_q[DIV_STEPS].sat_hi) begin
      pct_next = PCT_FULL;
    end else if (div_q[DIV_STEPS].sat_lo) begin
      pct_next = PCT_EMPTY;
    end else if (div_q[DIV_STEPS].zspan) begin
      pct_next = div_q[DIV_STEPS].base;
    end else if (sum_pct > {1'b0, PCT_FULL}) begin
      pct_next = PCT_FULL;
    end else begin
      pct_next = sum_pct[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    charge_percent <= pct_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_q[DIV_STEPS].valid;
    end
  end

  // result never exceeds full charge
  `BVP_ASSERT_IMP(a_pct_range, done, charge_percent <= PCT_FULL)
  // every taken request yields a result after the fixed latency
  `BVP_ASSERT_LAT(a_latency, start && !busy, done)
  // an in-range voltage picks exactly one segment
  `BVP_ASSERT_IMP(a_seg_onehot, v2 && !hi2 && !lo2, $onehot(seg_hot))

endmodule
